@@ hw/rtl/bmft_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bmft_pkg
// Shared constants and controller/datapath interface types for the battery
// monitor frame table.
// ---------------------------------------------------------------------------
package bmft_pkg;

    // default number of battery modules
    localparam int DEF_MODULES = 12;

    // table geometry per module
    localparam int PAIRS_PER_MOD     = 4;
    localparam int CELLS_PER_MOD     = 8;
    localparam int TEMP_ROWS_PER_MOD = 3;

    // frame acceptance window
    localparam logic [10:0] ID_LOW   = 11'h611;
    localparam logic [10:0] ID_HIGH  = 11'h6C4;
    localparam logic [10:0] ID_BASE  = 11'h600;
    localparam logic [3:0]  LEN_CODE = 4'd8;
    localparam logic [3:0]  PAIR_MAX = 4'd4;

    // temperature byte offset
    localparam logic [7:0] TEMP_OFFSET = 8'd50;

    // pair that carries no temperature
    localparam logic [1:0] PAIR_NO_TEMP = 2'd3;
    // pair whose temperatures sit one byte earlier
    localparam logic [1:0] PAIR_SHIFTED = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load;    // capture the input transfer, clear accumulators
        logic write;   // store an accepted frame
        logic walk;    // read the next table row
        logic emit;    // load the output register
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic walk_last;   // current walk row is the last one
    } t_dp_stat;

endpackage
`default_nettype wire

@@ hw/rtl/bmft_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bmft_ctrl
// Sequencer: takes one transfer at a time, runs the frame write or the
// table walk, and hands the result to the output register.
// ---------------------------------------------------------------------------
module bmft_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_command,
    input  wire logic               i_out_stall,
    input  wire bmft_pkg::t_dp_stat i_stat,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output bmft_pkg::t_dp_cmd       o_cmd
);
    import bmft_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FRAME = 5'b00010,
        S_WALK  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    // output register can take a new result
    assign slot_free = !r_out_valid || !i_out_stall;

    // commands
    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.write = (r_state == S_FRAME);
        o_cmd.walk  = (r_state == S_WALK);
        o_cmd.emit  = (r_state == S_OUT) && slot_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_command ? S_WALK : S_FRAME;
                end
            end
            S_FRAME: n_state = S_OUT;
            S_WALK: begin
                if (i_stat.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_OUT;
            S_OUT: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output valid: set on emit, cleared on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

@@ hw/rtl/bmft_datapath.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bmft_datapath
// Frame decode, cell and temperature tables, per-module counters, walk
// accumulators and the output register.
// ---------------------------------------------------------------------------
module bmft_datapath #(
    parameter int MODULES = bmft_pkg::DEF_MODULES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bmft_pkg::t_dp_cmd  i_cmd,
    output bmft_pkg::t_dp_stat      o_stat,
    input  wire logic               i_command,
    input  wire logic [10:0]        i_identifier,
    input  wire logic               i_extended,
    input  wire logic [3:0]         i_length_code,
    input  wire logic [63:0]        i_payload,
    input  wire logic [31:0]        i_now_ms,
    input  wire logic [3:0]         i_view_index,
    output logic                    o_accepted,
    output logic signed [4:0]       o_latest_module,
    output logic [15:0]             o_min_cell_raw,
    output logic [15:0]             o_max_cell_raw,
    output logic [22:0]             o_cell_sum,
    output logic [6:0]              o_cell_count,
    output logic signed [7:0]       o_min_temp,
    output logic signed [7:0]       o_max_temp,
    output logic                    o_temp_seen,
    output logic [31:0]             o_frame_count,
    output logic [31:0]             o_view_frames,
    output logic [31:0]             o_view_age_ms
);
    import bmft_pkg::*;

    localparam int MW    = (MODULES > 1) ? $clog2(MODULES) : 1;
    localparam int RW    = MW + 2;
    localparam int CROWS = MODULES * PAIRS_PER_MOD;
    localparam int TROWS = MODULES * TEMP_ROWS_PER_MOD;
    localparam int TW    = $clog2(TROWS);

    // captured item
    logic        r_cmd;
    logic [10:0] r_id;
    logic        r_ext;
    logic [3:0]  r_len;
    logic [63:0] r_pl;
    logic [31:0] r_now;
    logic [3:0]  r_view;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_id   <= i_identifier;
            r_ext  <= i_extended;
            r_len  <= i_length_code;
            r_pl   <= i_payload;
            r_now  <= i_now_ms;
            r_view <= i_view_index;
        end
    end

    // frame decode
    logic [10:0]   id_off;
    logic [3:0]    mnib, pnib, mod_full, pair_full;
    logic [MW-1:0] mod;
    logic [1:0]    pair;
    logic          frame_ok;
    logic [RW-1:0] crow;
    logic [RW:0]   trow_full;
    logic [TW-1:0] trow;
    logic [15:0]   v1, v2;
    logic [7:0]    tb0, tb1, t0, t1;
    logic          has_temp;

    always_comb begin
        id_off    = r_id - ID_BASE;
        mnib      = id_off[7:4];
        pnib      = r_id[3:0];
        frame_ok  = !r_ext && (r_len == LEN_CODE)
                    && (r_id >= ID_LOW) && (r_id <= ID_HIGH)
                    && (mnib >= 4'd1) && (mnib <= 4'(MODULES))
                    && (pnib >= 4'd1) && (pnib <= PAIR_MAX);
        mod_full  = mnib - 4'd1;
        pair_full = pnib - 4'd1;
        mod       = mod_full[MW-1:0];
        pair      = pair_full[1:0];
        crow      = {mod, pair};
        // row = module * 3 + pair
        trow_full = (RW+1)'({mod, 1'b0}) + (RW+1)'(mod) + (RW+1)'(pair);
        trow      = trow_full[TW-1:0];
        v1        = r_pl[31:16];
        v2        = r_pl[15:0];
        // the third pair takes its temperatures from bytes 1 and 2
        tb0       = (pair == PAIR_SHIFTED) ? r_pl[55:48] : r_pl[47:40];
        tb1       = (pair == PAIR_SHIFTED) ? r_pl[47:40] : r_pl[39:32];
        t0        = tb0 - TEMP_OFFSET;
        t1        = tb1 - TEMP_OFFSET;
        has_temp  = (pair != PAIR_NO_TEMP);
    end

    // cell and temperature memories, write side
    logic [31:0] cell_mem [CROWS];
    logic [15:0] temp_mem [TROWS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && frame_ok) begin
            cell_mem[crow] <= {v1, v2};
            if (has_temp) begin
                temp_mem[trow] <= {t0, t1};
            end
        end
    end

    // walk row counter
    logic [RW-1:0] r_walk;
    logic [TW-1:0] twalk;
    logic          twalk_in;

    assign twalk    = r_walk[TW-1:0];
    assign twalk_in = (r_walk < RW'(TROWS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_walk <= '0;
        end else if (i_cmd.walk) begin
            r_walk <= r_walk + RW'(1);
        end
    end

    assign o_stat.walk_last = (r_walk == RW'(CROWS - 1));

    // memory read side
    logic [31:0] r_crd;
    logic [15:0] r_trd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk) begin
            r_crd <= cell_mem[r_walk];
            if (twalk_in) begin
                r_trd <= temp_mem[twalk];
            end
        end
    end

    // valid marks, cleared by reset
    logic [1:0] r_cok [CROWS];
    logic [1:0] r_tok [TROWS];
    logic [1:0] r_cok_rd, r_tok_rd;
    logic       r_acc_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CROWS; i++) begin
                r_cok[i] <= 2'b00;
            end
            for (int i = 0; i < TROWS; i++) begin
                r_tok[i] <= 2'b00;
            end
            r_cok_rd <= 2'b00;
            r_tok_rd <= 2'b00;
            r_acc_en <= 1'b0;
        end else begin
            if (i_cmd.write && frame_ok) begin
                r_cok[crow] <= {v1 != 16'd0, v2 != 16'd0};
                if (has_temp) begin
                    r_tok[trow] <= {tb0 != 8'd0, tb1 != 8'd0};
                end
            end
            if (i_cmd.walk) begin
                r_cok_rd <= r_cok[r_walk];
                r_tok_rd <= twalk_in ? r_tok[twalk] : 2'b00;
            end
            r_acc_en <= i_cmd.walk;
        end
    end

    // walk accumulators
    logic [15:0]        r_mn, r_mx;
    logic [22:0]        r_sum;
    logic [6:0]         r_cnt;
    logic signed [7:0]  r_tmin, r_tmax;
    logic               r_any;
    logic [15:0]        ca, cb, mn1, mn2, mx1, mx2;
    logic signed [7:0]  ta, tb, tmn1, tmn2, tmx1, tmx2;
    logic [22:0]        n_sum;
    logic [6:0]         n_cnt;

    always_comb begin
        ca    = r_crd[31:16];
        cb    = r_crd[15:0];
        mn1   = (r_cok_rd[1] && (ca < r_mn)) ? ca : r_mn;
        mn2   = (r_cok_rd[0] && (cb < mn1)) ? cb : mn1;
        mx1   = (r_cok_rd[1] && (ca > r_mx)) ? ca : r_mx;
        mx2   = (r_cok_rd[0] && (cb > mx1)) ? cb : mx1;
        n_sum = r_sum + (r_cok_rd[1] ? 23'(ca) : 23'd0)
                      + (r_cok_rd[0] ? 23'(cb) : 23'd0);
        n_cnt = r_cnt + 7'(r_cok_rd[1]) + 7'(r_cok_rd[0]);
        ta    = signed'(r_trd[15:8]);
        tb    = signed'(r_trd[7:0]);
        tmn1  = (r_tok_rd[1] && (ta < r_tmin)) ? ta : r_tmin;
        tmn2  = (r_tok_rd[0] && (tb < tmn1)) ? tb : tmn1;
        tmx1  = (r_tok_rd[1] && (ta > r_tmax)) ? ta : r_tmax;
        tmx2  = (r_tok_rd[0] && (tb > tmx1)) ? tb : tmx1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mn   <= 16'hFFFF;
            r_mx   <= 16'h0000;
            r_sum  <= '0;
            r_cnt  <= '0;
            r_tmin <= 8'sd127;
            r_tmax <= -8'sd127;
            r_any  <= 1'b0;
        end else if (r_acc_en) begin
            r_mn   <= mn2;
            r_mx   <= mx2;
            r_sum  <= n_sum;
            r_cnt  <= n_cnt;
            r_tmin <= tmn2;
            r_tmax <= tmx2;
            r_any  <= r_any || (r_tok_rd != 2'b00);
        end
    end

    // per-module time stamps and counts, latest module, total count
    logic [31:0]       r_mod_time   [MODULES];
    logic [31:0]       r_mod_frames [MODULES];
    logic signed [4:0] r_latest;
    logic [31:0]       r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MODULES; i++) begin
                r_mod_time[i]   <= '0;
                r_mod_frames[i] <= '0;
            end
            r_latest <= -5'sd1;
            r_total  <= '0;
        end else if (i_cmd.write && frame_ok) begin
            r_mod_time[mod]   <= r_now;
            r_mod_frames[mod] <= r_mod_frames[mod] + 32'd1;
            r_latest          <= signed'(5'(mod));
            r_total           <= r_total + 32'd1;
        end
    end

    // viewed module lookup
    logic          view_in;
    logic [MW-1:0] vidx;

    assign view_in = (r_view < 4'(MODULES));
    assign vidx    = r_view[MW-1:0];

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_accepted      <= !r_cmd && frame_ok;
            o_latest_module <= r_latest;
            if (r_cmd) begin
                o_min_cell_raw <= r_mn;
                o_max_cell_raw <= r_mx;
                o_cell_sum     <= r_sum;
                o_cell_count   <= r_cnt;
                o_min_temp     <= r_tmin;
                o_max_temp     <= r_tmax;
                o_temp_seen    <= r_any;
                o_frame_count  <= r_total;
                o_view_frames  <= view_in ? r_mod_frames[vidx] : 32'd0;
                o_view_age_ms  <= view_in ? (r_now - r_mod_time[vidx]) : 32'd0;
            end else begin
                o_min_cell_raw <= '0;
                o_max_cell_raw <= '0;
                o_cell_sum     <= '0;
                o_cell_count   <= '0;
                o_min_temp     <= '0;
                o_max_temp     <= '0;
                o_temp_seen    <= 1'b0;
                o_frame_count  <= '0;
                o_view_frames  <= '0;
                o_view_age_ms  <= '0;
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/battery_monitor_frame_table_top.sv @@
`default_nettype none
// Frame: the sequencer runs the frame write state, then the output state
//   loads the result register; the next transfer is taken back in idle.
// Query: walks MODULES*4 table rows, one row per cycle through the memory
//   read port, then a drain state and the output state, which loads the
//   result; the next transfer is taken back in idle; an output stall
//   holds the sequencer until the result register frees.
// Reset clears valid marks, module counters and the latest module at once.
// ---------------------------------------------------------------------------
// battery_monitor_frame_table_top
// Stores battery module frames in a cell and temperature table and answers
// pack statistics queries.
// ---------------------------------------------------------------------------
module battery_monitor_frame_table_top #(
    parameter int MODULES = bmft_pkg::DEF_MODULES
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic         i_command,
    input  wire logic [10:0]  i_identifier,
    input  wire logic         i_extended,
    input  wire logic [3:0]   i_length_code,
    input  wire logic [63:0]  i_payload,
    input  wire logic [31:0]  i_now_ms,
    input  wire logic [3:0]   i_view_index,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic              o_accepted,
    output logic signed [4:0] o_latest_module,
    output logic [15:0]       o_min_cell_raw,
    output logic [15:0]       o_max_cell_raw,
    output logic [22:0]       o_cell_sum,
    output logic [6:0]        o_cell_count,
    output logic signed [7:0] o_min_temp,
    output logic signed [7:0] o_max_temp,
    output logic              o_temp_seen,
    output logic [31:0]       o_frame_count,
    output logic [31:0]       o_view_frames,
    output logic [31:0]       o_view_age_ms
);
    import bmft_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer
    bmft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (dp_cmd)
    );

    // tables, accumulators and output register
    bmft_datapath #(
        .MODULES (MODULES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_command       (i_command),
        .i_identifier    (i_identifier),
        .i_extended      (i_extended),
        .i_length_code   (i_length_code),
        .i_payload       (i_payload),
        .i_now_ms        (i_now_ms),
        .i_view_index    (i_view_index),
        .o_accepted      (o_accepted),
        .o_latest_module (o_latest_module),
        .o_min_cell_raw  (o_min_cell_raw),
        .o_max_cell_raw  (o_max_cell_raw),
        .o_cell_sum      (o_cell_sum),
        .o_cell_count    (o_cell_count),
        .o_min_temp      (o_min_temp),
        .o_max_temp      (o_max_temp),
        .o_temp_seen     (o_temp_seen),
        .o_frame_count   (o_frame_count),
        .o_view_frames   (o_view_frames),
        .o_view_age_ms   (o_view_age_ms)
    );

    // one item in flight: busy right after an input transfer
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in flight");

    // a stored frame reports no statistics
    a_frame_no_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accepted) |-> (o_cell_count == 7'd0 && o_frame_count == 32'd0))
        else $error("frame result carries statistics");

    // no valid cells means empty sum and maximum
    a_empty_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_cell_count == 7'd0) |->
        (o_cell_sum == 23'd0 && o_max_cell_raw == 16'd0))
        else $error("cell sum or maximum without valid cells");

    // temperature range ordered when any temperature is valid
    a_temp_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_temp_seen) |-> (o_min_temp <= o_max_temp))
        else $error("temperature minimum above maximum");

endmodule
`default_nettype wire

@@ dv/tb_battery_monitor_frame_table_top.sv @@
// ---------------------------------------------------------------------------
// tb_battery_monitor_frame_table_top
// Self-checking bench for the battery monitor frame table. A directed
// walk covers frame acceptance limits, pair layouts, temperature wrap and
// view corner cases. A random phase follows, made mostly of well-formed
// frames with shaped payloads plus queries, broken frames and noise.
// Every result is compared field by field with a behavioral model of
// the table. Random idle bursts on both channels are switched off near
// the end of the run.
// ---------------------------------------------------------------------------
module tb_battery_monitor_frame_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bmft_pkg::*;

    localparam int NUM_MODS      = DEF_MODULES;
    localparam int TEMPS_PER_MOD = 6;
    localparam int RANDOM_ITEMS  = 577;
    localparam int CALM_ITEMS    = 100;
    localparam int SWEEP_AT      = 200;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_CAP     = 40;

    typedef enum logic {
        CMD_FRAME = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd        command;
        logic [10:0] identifier;
        logic        extended;
        logic [3:0]  length_code;
        logic [63:0] payload;
        logic [31:0] now_ms;
        logic [3:0]  view_index;
    } t_bus_cmd;

    typedef struct packed {
        logic               accepted;
        logic signed [4:0]  latest_module;
        logic [15:0]        min_cell_raw;
        logic [15:0]        max_cell_raw;
        logic [22:0]        cell_sum;
        logic [6:0]         cell_count;
        logic signed [7:0]  min_temp;
        logic signed [7:0]  max_temp;
        logic               temp_seen;
        logic [31:0]        frame_count;
        logic [31:0]        view_frames;
        logic [31:0]        view_age_ms;
    } t_pack_report;

    // dut ports
    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_command;
    logic [10:0]       i_identifier;
    logic              i_extended;
    logic [3:0]        i_length_code;
    logic [63:0]       i_payload;
    logic [31:0]       i_now_ms;
    logic [3:0]        i_view_index;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_accepted;
    logic signed [4:0] o_latest_module;
    logic [15:0]       o_min_cell_raw;
    logic [15:0]       o_max_cell_raw;
    logic [22:0]       o_cell_sum;
    logic [6:0]        o_cell_count;
    logic signed [7:0] o_min_temp;
    logic signed [7:0] o_max_temp;
    logic              o_temp_seen;
    logic [31:0]       o_frame_count;
    logic [31:0]       o_view_frames;
    logic [31:0]       o_view_age_ms;

    // model of the table contents
    logic [15:0]       volt_raw  [NUM_MODS*CELLS_PER_MOD];
    logic              volt_ok   [NUM_MODS*CELLS_PER_MOD];
    logic [7:0]        temp_deg  [NUM_MODS*TEMPS_PER_MOD];
    logic              temp_ok   [NUM_MODS*TEMPS_PER_MOD];
    logic [7:0]        bal_mask  [NUM_MODS];
    logic [31:0]       stamp_ms  [NUM_MODS];
    logic [31:0]       mod_frames[NUM_MODS];
    logic signed [4:0] last_mod;
    logic [31:0]       frames_all;

    t_pack_report expected_reports[$];
    t_bus_cmd     plan_cmd[$];
    bit           plan_fixed[$];
    t_pack_report plan_want[$];

    logic [31:0] clock_ms;
    bit          calm = 1'b0;
    int          n_errors = 0;
    int          n_checked = 0;
    int          n_stored = 0;
    int          n_rejected = 0;
    int          n_queries = 0;
    int          cycles = 0;

    battery_monitor_frame_table_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_identifier    (i_identifier),
        .i_extended      (i_extended),
        .i_length_code   (i_length_code),
        .i_payload       (i_payload),
        .i_now_ms        (i_now_ms),
        .i_view_index    (i_view_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_accepted      (o_accepted),
        .o_latest_module (o_latest_module),
        .o_min_cell_raw  (o_min_cell_raw),
        .o_max_cell_raw  (o_max_cell_raw),
        .o_cell_sum      (o_cell_sum),
        .o_cell_count    (o_cell_count),
        .o_min_temp      (o_min_temp),
        .o_max_temp      (o_max_temp),
        .o_temp_seen     (o_temp_seen),
        .o_frame_count   (o_frame_count),
        .o_view_frames   (o_view_frames),
        .o_view_age_ms   (o_view_age_ms)
    );

    // clock
    always #1ns i_clk = ~i_clk;

    // empty table after reset
    function automatic void table_clear();
        foreach (volt_raw[i]) begin
            volt_raw[i] = '0;
            volt_ok[i]  = 1'b0;
        end
        foreach (temp_deg[i]) begin
            temp_deg[i] = '0;
            temp_ok[i]  = 1'b0;
        end
        foreach (bal_mask[i]) begin
            bal_mask[i]   = '0;
            stamp_ms[i]   = '0;
            mod_frames[i] = '0;
        end
        last_mod   = -5'sd1;
        frames_all = '0;
    endfunction

    function automatic logic [7:0] byte_of(logic [63:0] pl, int k);
        return pl[63-8*k -: 8];
    endfunction

    function automatic void store_temp(int m, int slot, logic [7:0] b);
        temp_deg[m*TEMPS_PER_MOD+slot] = b - TEMP_OFFSET;
        temp_ok[m*TEMPS_PER_MOD+slot]  = (b != 8'd0);
    endfunction

    // apply one command to the table and return the report it produces
    function automatic t_pack_report table_update(t_bus_cmd c);
        t_pack_report      r;
        logic [10:0]       rel;
        logic [3:0]        mnib;
        logic [3:0]        pnib;
        logic [1:0]        pair;
        int                m;
        int                base;
        logic [15:0]       mn;
        logic [15:0]       mx;
        logic [31:0]       sum;
        int                cnt;
        int                tmin;
        int                tmax;
        logic              any;
        logic signed [7:0] t;

        r = '0;
        if (c.command == CMD_FRAME) begin
            rel  = c.identifier - ID_BASE;
            mnib = rel[7:4];
            pnib = c.identifier[3:0];
            if (!c.extended && c.length_code == LEN_CODE &&
                c.identifier >= ID_LOW && c.identifier <= ID_HIGH &&
                mnib >= 4'd1 && mnib <= NUM_MODS &&
                pnib >= 4'd1 && pnib <= PAIR_MAX) begin
                m    = mnib - 1;
                pair = 2'(pnib - 4'd1);
                base = m * CELLS_PER_MOD + pair * 2;
                volt_raw[base]   = c.payload[31:16];
                volt_raw[base+1] = c.payload[15:0];
                volt_ok[base]    = (c.payload[31:16] != 16'd0);
                volt_ok[base+1]  = (c.payload[15:0] != 16'd0);
                case (pair)
                    2'd0: begin
                        bal_mask[m] = byte_of(c.payload, 1);
                        store_temp(m, 0, byte_of(c.payload, 2));
                        store_temp(m, 1, byte_of(c.payload, 3));
                    end
                    2'd1: begin
                        store_temp(m, 2, byte_of(c.payload, 2));
                        store_temp(m, 3, byte_of(c.payload, 3));
                    end
                    PAIR_SHIFTED: begin
                        store_temp(m, 4, byte_of(c.payload, 1));
                        store_temp(m, 5, byte_of(c.payload, 2));
                    end
                    default: begin
                    end
                endcase
                stamp_ms[m]   = c.now_ms;
                mod_frames[m] = mod_frames[m] + 32'd1;
                last_mod      = 5'(m);
                frames_all    = frames_all + 32'd1;
                r.accepted    = 1'b1;
            end
        end else begin
            mn   = 16'hFFFF;
            mx   = 16'h0000;
            sum  = '0;
            cnt  = 0;
            tmin = 127;
            tmax = -127;
            any  = 1'b0;
            foreach (volt_raw[i]) begin
                if (volt_ok[i]) begin
                    if (volt_raw[i] < mn) mn = volt_raw[i];
                    if (volt_raw[i] > mx) mx = volt_raw[i];
                    sum = sum + volt_raw[i];
                    cnt++;
                end
            end
            foreach (temp_deg[i]) begin
                if (temp_ok[i]) begin
                    t = temp_deg[i];
                    if (int'(t) < tmin) tmin = t;
                    if (int'(t) > tmax) tmax = t;
                    any = 1'b1;
                end
            end
            r.min_cell_raw = mn;
            r.max_cell_raw = mx;
            r.cell_sum     = sum[22:0];
            r.cell_count   = 7'(cnt);
            r.min_temp     = 8'(tmin);
            r.max_temp     = 8'(tmax);
            r.temp_seen    = any;
            r.frame_count  = frames_all;
            if (c.view_index < NUM_MODS) begin
                r.view_frames = mod_frames[c.view_index];
                r.view_age_ms = c.now_ms - stamp_ms[c.view_index];
            end
        end
        r.latest_module = last_mod;
        return r;
    endfunction

    // stimulus builders
    function automatic t_bus_cmd frame_cmd(logic [10:0] id, logic ext, logic [3:0] len,
                                           logic [63:0] pl, logic [31:0] now);
        return '{CMD_FRAME, id, ext, len, pl, now, 4'd0};
    endfunction

    function automatic t_bus_cmd query_cmd(logic [3:0] view, logic [31:0] now);
        return '{CMD_QUERY, 11'd0, 1'b0, 4'd0, 64'd0, now, view};
    endfunction

    function automatic t_pack_report frame_ack(logic acc, logic signed [4:0] latest);
        t_pack_report r;
        r               = '0;
        r.accepted      = acc;
        r.latest_module = latest;
        return r;
    endfunction

    function automatic void plan(t_bus_cmd c, bit fixed, t_pack_report want);
        plan_cmd.push_back(c);
        plan_fixed.push_back(fixed);
        plan_want.push_back(want);
    endfunction

    function automatic logic [31:0] next_now();
        if ($urandom_range(0, 15) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, 500);
        return clock_ms;
    endfunction

    // payload biased toward empty and full bytes and empty cell words
    function automatic logic [63:0] shaped_payload();
        logic [63:0] pl;
        for (int k = 0; k < 8; k++) begin
            case ($urandom_range(0, 7))
                0: pl[63-8*k -: 8] = 8'h00;
                1: pl[63-8*k -: 8] = 8'hFF;
                default: pl[63-8*k -: 8] = 8'($urandom);
            endcase
        end
        if ($urandom_range(0, 7) == 0) pl[31:16] = 16'h0000;
        if ($urandom_range(0, 7) == 0) pl[15:0] = 16'h0000;
        if ($urandom_range(0, 15) == 0) pl[31:16] = 16'hFFFF;
        if ($urandom_range(0, 15) == 0) pl[15:0] = 16'hFFFF;
        return pl;
    endfunction

    function automatic t_bus_cmd random_cmd();
        t_bus_cmd c;
        int       r;
        int       v;

        c.command     = t_cmd'(1'($urandom));
        c.identifier  = 11'($urandom);
        c.extended    = 1'($urandom);
        c.length_code = 4'($urandom);
        c.payload     = {$urandom, $urandom};
        c.now_ms      = next_now();
        c.view_index  = 4'($urandom);
        r = $urandom_range(0, 99);
        if (r < 10) begin
            c.command = CMD_QUERY;
        end else if (r < 93) begin
            // well-formed frame, sometimes broken in one way
            c.command     = CMD_FRAME;
            c.identifier  = ID_BASE + 11'($urandom_range(1, NUM_MODS) * 16 +
                                          $urandom_range(1, 4));
            c.extended    = 1'b0;
            c.length_code = LEN_CODE;
            c.payload     = shaped_payload();
            if (r >= 82) begin
                case ($urandom_range(0, 3))
                    0: c.extended = 1'b1;
                    1: c.length_code = LEN_CODE ^ 4'($urandom_range(1, 15));
                    2: begin
                        v = $urandom_range(0, 11);
                        c.identifier[3:0] = (v == 0) ? 4'd0 : 4'(v + 4);
                    end
                    default: begin
                        if ($urandom_range(0, 1) == 0)
                            c.identifier = 11'($urandom_range(0, 'h610));
                        else
                            c.identifier = 11'($urandom_range('h6C5, 'h7FF));
                    end
                endcase
            end
        end
        return c;
    endfunction

    // one input transfer, with an optional idle burst ahead of it
    task automatic send_transfer(t_bus_cmd c, bit fixed, t_pack_report want);
        t_pack_report predicted;
        int           gap;

        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_command     <= c.command;
        i_identifier  <= c.identifier;
        i_extended    <= c.extended;
        i_length_code <= c.length_code;
        i_payload     <= c.payload;
        i_now_ms      <= c.now_ms;
        i_view_index  <= c.view_index;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = table_update(c);
        expected_reports.push_back(fixed ? want : predicted);
        if (c.command == CMD_QUERY) n_queries++;
        else if (predicted.accepted) n_stored++;
        else n_rejected++;
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
    endtask

    // mismatch reporting
    task automatic report_error(string msg);
        if (n_errors < PRINT_CAP) $display("ERROR result %0d: %s", n_checked, msg);
        n_errors++;
    endtask

    task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) report_error($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic check_report(t_pack_report got);
        t_pack_report want;
        if (expected_reports.size() == 0) begin
            report_error("result with no transfer pending");
        end else begin
            want = expected_reports.pop_front();
            compare_field("accepted", got.accepted, want.accepted);
            compare_field("latest_module", got.latest_module, want.latest_module);
            compare_field("min_cell_raw", got.min_cell_raw, want.min_cell_raw);
            compare_field("max_cell_raw", got.max_cell_raw, want.max_cell_raw);
            compare_field("cell_sum", got.cell_sum, want.cell_sum);
            compare_field("cell_count", got.cell_count, want.cell_count);
            compare_field("min_temp", got.min_temp, want.min_temp);
            compare_field("max_temp", got.max_temp, want.max_temp);
            compare_field("temp_seen", got.temp_seen, want.temp_seen);
            compare_field("frame_count", got.frame_count, want.frame_count);
            compare_field("view_frames", got.view_frames, want.view_frames);
            compare_field("view_age_ms", got.view_age_ms, want.view_age_ms);
        end
        n_checked++;
    endtask

    // result monitor
    always @(posedge i_clk) begin : take_reports
        t_pack_report got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_accepted, o_latest_module, o_min_cell_raw, o_max_cell_raw,
                    o_cell_sum, o_cell_count, o_min_temp, o_max_temp, o_temp_seen,
                    o_frame_count, o_view_frames, o_view_age_ms};
            check_report(got);
        end
    end

    // receiver stall bursts
    always @(negedge i_clk) begin : stall_gen
        int run;
        bit hold;
        if (run == 0) begin
            hold = !calm && ($urandom_range(0, 3) == 0);
            run  = hold ? $urandom_range(1, 14) : $urandom_range(1, 40);
        end
        i_out_stall <= hold && !calm;
        run--;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, expected_reports.size());
            $display("battery_monitor_frame_table_top regression: fail");
            $finish;
        end
    end

    // main sequence
    initial begin
        t_pack_report blank;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_out_stall   = 1'b0;
        i_command     = CMD_FRAME;
        i_identifier  = '0;
        i_extended    = 1'b0;
        i_length_code = '0;
        i_payload     = '0;
        i_now_ms      = '0;
        i_view_index  = '0;
        clock_ms      = $urandom;
        table_clear();

        // empty table, then rejected frames before any accepted one
        blank = '{1'b0, -5'sd1, 16'hFFFF, 16'h0000, 23'd0, 7'd0, 8'sd127, -8'sd127,
                  1'b0, 32'd0, 32'd0, 32'd1234};
        plan(query_cmd(4'd0, 32'd1234), 1, blank);
        blank.view_age_ms = 32'd0;
        plan(query_cmd(4'd15, 32'hFFFF_FFFF), 1, blank);
        plan(frame_cmd(ID_LOW, 1'b1, LEN_CODE, '1, 32'd10), 1, frame_ack(1'b0, -5'sd1));
        plan(frame_cmd(ID_LOW, 1'b0, 4'd7, '1, 32'd11), 1, frame_ack(1'b0, -5'sd1));
        plan(frame_cmd(ID_LOW, 1'b0, 4'd15, '1, 32'd12), 1, frame_ack(1'b0, -5'sd1));
        plan(frame_cmd(ID_LOW, 1'b0, 4'd0, '1, 32'd13), 1, frame_ack(1'b0, -5'sd1));
        plan(frame_cmd(11'h610, 1'b0, LEN_CODE, '1, 32'd14), 1, frame_ack(1'b0, -5'sd1));
        plan(frame_cmd(11'h6C5, 1'b0, LEN_CODE, '1, 32'd15), 1, frame_ack(1'b0, -5'sd1));
        plan(frame_cmd(11'h620, 1'b0, LEN_CODE, '1, 32'd16), 1, frame_ack(1'b0, -5'sd1));
        plan(frame_cmd(11'h615, 1'b0, LEN_CODE, '1, 32'd17), 1, frame_ack(1'b0, -5'sd1));
        plan(frame_cmd(11'h61F, 1'b0, LEN_CODE, '1, 32'd18), 1, frame_ack(1'b0, -5'sd1));
        plan(frame_cmd(11'h7FF, 1'b1, 4'd15, '1, 32'd19), 1, frame_ack(1'b0, -5'sd1));
        plan(frame_cmd(11'h000, 1'b0, LEN_CODE, '0, 32'd20), 1, frame_ack(1'b0, -5'sd1));
        // every pair, first and last module, zero bytes and temperature wrap
        plan(frame_cmd(ID_LOW, 1'b0, LEN_CODE, '1, 32'd100), 1, frame_ack(1'b1, 5'sd0));
        plan(frame_cmd(11'h612, 1'b0, LEN_CODE, '0, 32'd200), 1, frame_ack(1'b1, 5'sd0));
        plan(frame_cmd(11'h613, 1'b0, LEN_CODE, 64'h00_81_01_B2_0001_FFFE, 32'd300), 1,
             frame_ack(1'b1, 5'sd0));
        plan(frame_cmd(11'h614, 1'b0, LEN_CODE, 64'h5A5A_A5A5_8000_0000, 32'd400), 1,
             frame_ack(1'b1, 5'sd0));
        plan(frame_cmd(11'h6C1, 1'b0, LEN_CODE, 64'h00_AA_32_B1_8000_7FFF,
                       32'hFFFF_FFF0), 1, frame_ack(1'b1, 5'sd11));
        plan(frame_cmd(11'h6C2, 1'b0, LEN_CODE, 64'h00_00_B2_01_0000_0001, 32'd500), 1,
             frame_ack(1'b1, 5'sd11));
        plan(frame_cmd(ID_HIGH, 1'b0, LEN_CODE, 64'hFFFF_FFFF_0000_FFFF, 32'd600), 1,
             frame_ack(1'b1, 5'sd11));
        // statistics: age wrap, never-updated module, view out of range
        plan(query_cmd(4'd11, 32'd5), 0, '0);
        plan(query_cmd(4'd0, 32'd300), 0, '0);
        plan(query_cmd(4'd5, 32'd7), 0, '0);
        plan(query_cmd(4'd12, 32'hDEAD_BEEF), 0, '0);

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan_cmd[i]) send_transfer(plan_cmd[i], plan_fixed[i], plan_want[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == SWEEP_AT) begin
                // let the pipe drain, then fill every pair with full words
                hold_until_drained();
                for (int m = 1; m <= NUM_MODS; m++)
                    for (int p = 1; p <= 4; p++)
                        send_transfer(frame_cmd(ID_BASE + 11'(m * 16 + p), 1'b0, LEN_CODE,
                                                '1, next_now()), 0, '0);
                send_transfer(query_cmd(4'($urandom_range(0, 15)), next_now()), 0, '0);
            end
            if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            send_transfer(random_cmd(), 0, '0);
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d frames stored, %0d frames rejected, %0d statistics queries",
                 n_stored, n_rejected, n_queries);
        $display("compared %0d results field by field, %0d mismatches",
                 n_checked, n_errors);
        if (n_errors == 0) begin
            $display("battery_monitor_frame_table_top regression: pass");
        end else begin
            $display("battery_monitor_frame_table_top regression: fail");
        end
        $finish;
    end

endmodule

@@ battery_monitor_frame_table_top.f @@
hw/rtl/bmft_pkg.sv
hw/rtl/bmft_ctrl.sv
hw/rtl/bmft_datapath.sv
hw/rtl/battery_monitor_frame_table_top.sv
dv/tb_battery_monitor_frame_table_top.sv
